// File: design/crg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crg_pkg
// Shared widths, register indexes, basis types and rounding helpers for the
// camera ray generator.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int COORD_W    = 16;
  localparam int COORD_FRAC = 8;
  localparam int BASIS_FRAC = 14;
  localparam int BASIS_W    = 16;
  localparam int OUT_W      = 20;
  localparam int FOCAL_W    = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = 34;

  localparam logic [CFG_IDX_W-1:0] CFG_EYE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EYE_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AIM_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AIM_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AIM_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd7;

  localparam logic signed [BASIS_W-1:0] UNIT_ONE = BASIS_W'(1 << BASIS_FRAC);
  localparam logic signed [PROD_W-1:0] UNIT_WIDE = PROD_W'(1 << BASIS_FRAC);
  localparam logic signed [PROD_W-1:0] OUT_MAX =
    PROD_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] OUT_MIN = -OUT_MAX - PROD_W'(1);

  typedef logic [2:0][COORD_W-1:0] coord3_t;
  typedef logic [2:0][BASIS_W-1:0] bvec_t;

  typedef struct packed {
    bvec_t w;
    bvec_t u;
    bvec_t v;
    logic  degen;
  } basis_t;

  // round by 2^BASIS_FRAC, half away from zero
  function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] r;
    m = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    r = (m + (PROD_W'(1) << (BASIS_FRAC - 1))) >> BASIS_FRAC;
    return x[PROD_W-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [BASIS_W-1:0] cap_unit(input logic signed [PROD_W-1:0] x);
    logic signed [BASIS_W-1:0] r;
    if (x > UNIT_WIDE) begin
      r = UNIT_ONE;
    end else if (x < -UNIT_WIDE) begin
      r = -UNIT_ONE;
    end else begin
      r = BASIS_W'(x);
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] x);
    logic [OUT_W-1:0] r;
    if (x > OUT_MAX) begin
      r = OUT_W'(OUT_MAX);
    end else if (x < OUT_MIN) begin
      r = OUT_W'(OUT_MIN);
    end else begin
      r = OUT_W'(x);
    end
    return r;
  endfunction

endpackage

// File: design/crg_basis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crg_basis
// Sequencer that rebuilds the camera basis: normalizes eye - aim into w,
// up x w into u, then forms v = w x u, with a shared bit-serial square root
// and divider.
// ----------------------------------------------------------------------------
module crg_basis
  import crg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    go,
  input  coord3_t eye,
  input  coord3_t aim,
  output basis_t  basis,
  output logic    busy
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SETUP, S_SHIFT, S_SQ, S_SQRT,
    S_DIVINIT, S_DIV, S_DIVEND, S_MKH, S_CROSS
  } state_t;

  state_t             state_r, state_nxt;
  logic               pass_r, pass_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [17:0] c_r [3];
  logic signed [17:0] c_nxt [3];
  logic [2:0]         sgn_r, sgn_nxt;
  logic [29:0]        m_r [3];
  logic [29:0]        m_nxt [3];
  logic [29:0]        mx_r, mx_nxt;
  logic [61:0]        sq_n_r, sq_n_nxt;
  logic [30:0]        root_r, root_nxt;
  logic [32:0]        srem_r, srem_nxt;
  logic [31:0]        drem_r, drem_nxt;
  logic [14:0]        dnum_r, dnum_nxt;
  logic [14:0]        q_r, q_nxt;
  basis_t             basis_r, basis_nxt;

  always_comb begin
    logic [16:0]               ab;
    logic [29:0]               mx;
    logic [59:0]               sq;
    logic [34:0]               rem2;
    logic [34:0]               trial;
    logic [44:0]               num;
    logic [31:0]               dt;
    logic [14:0]               qc;
    logic signed [BASIS_W-1:0] qv;
    logic signed [2*BASIS_W-1:0] p0;
    logic signed [2*BASIS_W-1:0] p1;
    logic signed [PROD_W-1:0]  cr;
    logic [1:0]                j;
    logic [1:0]                k;
    state_nxt = state_r;
    pass_nxt  = pass_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    c_nxt     = c_r;
    sgn_nxt   = sgn_r;
    m_nxt     = m_r;
    mx_nxt    = mx_r;
    sq_n_nxt  = sq_n_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    drem_nxt  = drem_r;
    dnum_nxt  = dnum_r;
    q_nxt     = q_r;
    basis_nxt = basis_r;
    mx        = '0;
    ab        = '0;
    sq        = '0;
    rem2      = '0;
    trial     = '0;
    num       = '0;
    dt        = '0;
    qc        = '0;
    qv        = '0;
    p0        = '0;
    p1        = '0;
    cr        = '0;
    j         = 2'd0;
    k         = 2'd0;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          c_nxt[i] = 18'($signed(eye[i])) - 18'($signed(aim[i]));
        end
        pass_nxt  = 1'b0;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        for (int i = 0; i < 3; i++) begin
          ab = c_r[i][17] ? 17'(-c_r[i]) : 17'(c_r[i]);
          m_nxt[i]   = 30'(ab);
          sgn_nxt[i] = c_r[i][17];
          if (30'(ab) > mx) begin
            mx = 30'(ab);
          end
        end
        mx_nxt = mx;
        if (mx == '0) begin
          basis_nxt       = '0;
          basis_nxt.degen = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (mx_r[29]) begin
          sq_n_nxt  = '0;
          idx_nxt   = 2'd0;
          state_nxt = S_SQ;
        end else begin
          for (int i = 0; i < 3; i++) begin
            m_nxt[i] = {m_r[i][28:0], 1'b0};
          end
          mx_nxt = {mx_r[28:0], 1'b0};
        end
      end
      S_SQ: begin
        sq       = m_r[idx_r] * m_r[idx_r];
        sq_n_nxt = sq_n_r + 62'(sq);
        if (idx_r == 2'd2) begin
          root_nxt  = '0;
          srem_nxt  = '0;
          cnt_nxt   = 5'd30;
          state_nxt = S_SQRT;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      S_SQRT: begin
        rem2     = {srem_r, sq_n_r[61:60]};
        trial    = 35'({root_r, 2'b01});
        sq_n_nxt = {sq_n_r[59:0], 2'b00};
        if (rem2 >= trial) begin
          srem_nxt = 33'(rem2 - trial);
          root_nxt = {root_r[29:0], 1'b1};
        end else begin
          srem_nxt = 33'(rem2);
          root_nxt = {root_r[29:0], 1'b0};
        end
        if (cnt_r == '0) begin
          idx_nxt   = 2'd0;
          state_nxt = S_DIVINIT;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_DIVINIT: begin
        num       = {1'b0, m_r[idx_r], 14'b0} + 45'(root_r >> 1);
        drem_nxt  = 32'(num[44:15]);
        dnum_nxt  = num[14:0];
        q_nxt     = '0;
        cnt_nxt   = 5'd14;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        dt       = {drem_r[30:0], dnum_r[14]};
        dnum_nxt = {dnum_r[13:0], 1'b0};
        if (dt >= {1'b0, root_r}) begin
          drem_nxt = dt - {1'b0, root_r};
          q_nxt    = {q_r[13:0], 1'b1};
        end else begin
          drem_nxt = dt;
          q_nxt    = {q_r[13:0], 1'b0};
        end
        if (cnt_r == '0) begin
          state_nxt = S_DIVEND;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      S_DIVEND: begin
        qc = (q_r > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : q_r;
        qv = sgn_r[idx_r] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
        if (pass_r) begin
          basis_nxt.u[idx_r] = qv;
        end else begin
          basis_nxt.w[idx_r] = qv;
        end
        if (idx_r == 2'd2) begin
          idx_nxt   = 2'd0;
          state_nxt = pass_r ? S_CROSS : S_MKH;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = S_DIVINIT;
        end
      end
      S_MKH: begin
        c_nxt[0]  = 18'($signed(basis_r.w[2]));
        c_nxt[1]  = '0;
        c_nxt[2]  = -18'($signed(basis_r.w[0]));
        pass_nxt  = 1'b1;
        state_nxt = S_SETUP;
      end
      S_CROSS: begin
        case (idx_r)
          2'd0: begin
            j = 2'd1;
            k = 2'd2;
          end
          2'd1: begin
            j = 2'd2;
            k = 2'd0;
          end
          default: begin
            j = 2'd0;
            k = 2'd1;
          end
        endcase
        p0 = $signed(basis_r.w[j]) * $signed(basis_r.u[k]);
        p1 = $signed(basis_r.w[k]) * $signed(basis_r.u[j]);
        cr = PROD_W'(p0) - PROD_W'(p1);
        basis_nxt.v[idx_r] = cap_unit(rnd_shift(cr));
        if (idx_r == 2'd2) begin
          basis_nxt.degen = 1'b0;
          state_nxt       = S_IDLE;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a new write restarts the rebuild from the updated registers
    if (go) begin
      state_nxt = S_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      basis_r.w     <= {UNIT_ONE, 16'd0, 16'd0};
      basis_r.u     <= {16'd0, 16'd0, UNIT_ONE};
      basis_r.v     <= {16'd0, UNIT_ONE, 16'd0};
      basis_r.degen <= 1'b0;
    end else begin
      state_r <= state_nxt;
      basis_r <= basis_nxt;
    end
    pass_r <= pass_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    c_r    <= c_nxt;
    sgn_r  <= sgn_nxt;
    m_r    <= m_nxt;
    mx_r   <= mx_nxt;
    sq_n_r <= sq_n_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    drem_r <= drem_nxt;
    dnum_r <= dnum_nxt;
    q_r    <= q_nxt;
  end

  assign basis = basis_r;
  assign busy  = (state_r != S_IDLE);

endmodule

// File: design/camera_ray_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_ray_generator_unit
// Pinhole and orthographic camera ray generator with a stored camera basis.
// ----------------------------------------------------------------------------
// One ray per item, one item per clock while busy is low; each ray appears
// on the out_ ports after the input, product and output registers with a
// one-cycle out_valid strobe, and the receiver cannot stall. A write to an
// eye or aim register rebuilds the basis in a bit-serial square root and
// divider, with busy high through two normalizations and the cross product
// (degenerate if eye - aim or up x w is zero); another such write during
// a rebuild starts it over. Focal and mode writes take effect at once.
module camera_ray_generator_unit
  import crg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [COORD_W-1:0] in_screen_a,
  input  logic signed [COORD_W-1:0] in_screen_b,
  output logic                 out_valid,
  output logic signed [OUT_W-1:0] out_ray_origin_x,
  output logic signed [OUT_W-1:0] out_ray_origin_y,
  output logic signed [OUT_W-1:0] out_ray_origin_z,
  output logic signed [OUT_W-1:0] out_ray_dir_x,
  output logic signed [OUT_W-1:0] out_ray_dir_y,
  output logic signed [OUT_W-1:0] out_ray_dir_z,
  output logic                 out_basis_degenerate
);

  coord3_t             eye_r, aim_r;
  logic [FOCAL_W-1:0]  focal_r;
  logic                mode_r;
  logic                go;
  basis_t              basis;

  logic                v1_r, v2_r, ov_r;
  logic [COORD_W-1:0]  a_r, b_r;
  logic signed [PROD_W-1:0] pa_r [3];
  logic signed [PROD_W-1:0] pb_r [3];
  logic signed [PROD_W-1:0] pw_r [3];
  logic signed [PROD_W-1:0] pa_nxt [3];
  logic signed [PROD_W-1:0] pb_nxt [3];
  logic signed [PROD_W-1:0] pw_nxt [3];
  logic [OUT_W-1:0]    org_r [3];
  logic [OUT_W-1:0]    dir_r [3];
  logic [OUT_W-1:0]    org_nxt [3];
  logic [OUT_W-1:0]    dir_nxt [3];
  logic                degen_r;

  assign go = cfg_we && (cfg_idx < CFG_FOCAL);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_r   <= '0;
      aim_r   <= {-COORD_W'(1 << COORD_FRAC), 16'd0, 16'd0};
      focal_r <= FOCAL_W'(1 << COORD_FRAC);
      mode_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_EYE_X: eye_r[0] <= cfg_wdata;
        CFG_EYE_Y: eye_r[1] <= cfg_wdata;
        CFG_EYE_Z: eye_r[2] <= cfg_wdata;
        CFG_AIM_X: aim_r[0] <= cfg_wdata;
        CFG_AIM_Y: aim_r[1] <= cfg_wdata;
        CFG_AIM_Z: aim_r[2] <= cfg_wdata;
        CFG_FOCAL: focal_r  <= cfg_wdata[FOCAL_W-1:0];
        CFG_MODE:  mode_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  crg_basis u_basis (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .eye   (eye_r),
    .aim   (aim_r),
    .basis (basis),
    .busy  (busy)
  );

  // products of the screen coordinates with u and v, and of w with the focal or unit scale
  always_comb begin
    logic signed [COORD_W:0] scale;
    scale = mode_r ? $signed({2'b00, focal_r}) : (COORD_W + 1)'(1 << COORD_FRAC);
    for (int i = 0; i < 3; i++) begin
      pa_nxt[i] = PROD_W'($signed(a_r) * $signed(basis.u[i]));
      pb_nxt[i] = PROD_W'($signed(b_r) * $signed(basis.v[i]));
      pw_nxt[i] = PROD_W'($signed(basis.w[i]) * scale);
    end
  end

  // sum, round and saturate; zero origin and direction for a degenerate basis
  always_comb begin
    logic signed [PROD_W-1:0] plane;
    logic signed [PROD_W-1:0] eye_w;
    for (int i = 0; i < 3; i++) begin
      plane = pa_r[i] + pb_r[i];
      eye_w = PROD_W'($signed(eye_r[i]));
      if (basis.degen) begin
        org_nxt[i] = '0;
        dir_nxt[i] = '0;
      end else if (mode_r) begin
        org_nxt[i] = sat_out(eye_w);
        dir_nxt[i] = sat_out(rnd_shift(plane - pw_r[i]));
      end else begin
        org_nxt[i] = sat_out(rnd_shift((eye_w <<< BASIS_FRAC) + plane));
        dir_nxt[i] = sat_out(rnd_shift(-pw_r[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      ov_r <= v2_r;
    end
    a_r     <= in_screen_a;
    b_r     <= in_screen_b;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    pw_r    <= pw_nxt;
    org_r   <= org_nxt;
    dir_r   <= dir_nxt;
    degen_r <= basis.degen;
  end

  assign out_valid            = ov_r;
  assign out_ray_origin_x     = org_r[0];
  assign out_ray_origin_y     = org_r[1];
  assign out_ray_origin_z     = org_r[2];
  assign out_ray_dir_x        = dir_r[0];
  assign out_ray_dir_y        = dir_r[1];
  assign out_ray_dir_z        = dir_r[2];
  assign out_basis_degenerate = degen_r;

endmodule
